### hdl/tsls_pkg.sv
// shared constants, codes and types of the timestamp range line search unit
`default_nettype none
package tsls_pkg;

  // table geometry
  localparam int LINE_DEPTH   = 4096;
  localparam int ADDR_W       = $clog2(LINE_DEPTH);
  localparam int CNT_W        = ADDR_W + 1;
  localparam int SUM_W        = CNT_W + 1;
  localparam int TIME_W       = 48;

  // scan limits
  localparam int GAP_LIMIT    = 256;
  localparam int ORDER_SCAN   = 1024;
  localparam int ORDER_WINDOW = 16;
  localparam int WIN_W        = $clog2(ORDER_WINDOW + 1);

  // field widths
  localparam int REQ_W        = 2;
  localparam int POS_W        = 3;
  localparam int OUTC_W       = 3;

  // input beat layout, lowest bit first
  localparam int IN_DATA_W    = 128;
  localparam int IN_INDEX_LSB = 0;
  localparam int IN_HAS_BIT   = IN_INDEX_LSB + ADDR_W;
  localparam int IN_TV_LSB    = IN_HAS_BIT + 1;
  localparam int IN_TE_LSB    = IN_TV_LSB + TIME_W;
  localparam int IN_FROM_LSB  = IN_TE_LSB + TIME_W;
  localparam int OUT_DATA_W   = 32;

  // request kinds
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FIND  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RANGE = 2'd2;

  // find positions
  localparam logic [POS_W-1:0] POS_EMPTY  = 3'd0;
  localparam logic [POS_W-1:0] POS_NONE   = 3'd1;
  localparam logic [POS_W-1:0] POS_BEFORE = 3'd2;
  localparam logic [POS_W-1:0] POS_AT     = 3'd3;
  localparam logic [POS_W-1:0] POS_AFTER  = 3'd4;

  // range outcomes
  localparam logic [OUTC_W-1:0] OUTC_LIMITS   = 3'd0;
  localparam logic [OUTC_W-1:0] OUTC_END_LE   = 3'd1;
  localparam logic [OUTC_W-1:0] OUTC_NO_STAMP = 3'd2;
  localparam logic [OUTC_W-1:0] OUTC_AFTER    = 3'd3;
  localparam logic [OUTC_W-1:0] OUTC_BEFORE   = 3'd4;
  localparam logic [OUTC_W-1:0] OUTC_NO_LINES = 3'd5;

  // datapath operations
  localparam int OP_W = 5;
  typedef logic [OP_W-1:0] dp_op_t;
  localparam dp_op_t OP_NONE       = 5'd0;
  localparam dp_op_t OP_LOAD       = 5'd1;
  localparam dp_op_t OP_EMPTY      = 5'd2;
  localparam dp_op_t OP_FSTART     = 5'd3;
  localparam dp_op_t OP_BS_STEP    = 5'd4;
  localparam dp_op_t OP_FINAL_SCAN = 5'd5;
  localparam dp_op_t OP_SCAN_RD    = 5'd6;
  localparam dp_op_t OP_SCAN_EV    = 5'd7;
  localparam dp_op_t OP_SCAN_DONE  = 5'd8;
  localparam dp_op_t OP_ORD_START  = 5'd9;
  localparam dp_op_t OP_BK_RD      = 5'd10;
  localparam dp_op_t OP_BK_EV      = 5'd11;
  localparam dp_op_t OP_FW_START   = 5'd12;
  localparam dp_op_t OP_FW_RD      = 5'd13;
  localparam dp_op_t OP_FW_EV      = 5'd14;
  localparam dp_op_t OP_FIND_DONE  = 5'd15;
  localparam dp_op_t OP_OUT        = 5'd16;

  typedef struct packed {
    logic             has;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic [REQ_W-1:0] in_req;
    logic             range_bad;
    logic             cnt_zero;
    logic             low_lt_high;
    logic             scan_more;
    logic             rd_hit;
    logic             final_pass;
    logic             bk_more;
    logic             fw_more;
    logic             bk_viol;
    logic             fw_viol;
    logic             need_second;
    logic             out_busy;
  } dp_status_t;

endpackage
`default_nettype wire

### hdl/timestamp_range_line_search_unit.sv
// top level: configuration register, sequencer and search datapath
//
// usage
// - slave stream: one beat is one request; s_tuser is the request kind
//   (write entry, find, range), s_tdata carries the entry and search fields
// - write requests fill one table line and give no beat out
// - find and range requests give exactly one master beat each
// - apb port: line_count at byte address 0; the user must see that it is
//   written only while idle, the block itself does not enforce it
// - each table line examined is read, then evaluated, on the single table
//   port; a find runs about twelve binary search probes, each reading up to
//   256 lines, a final scan of up to 256 lines and an order check of up to
//   2048 lines that stops after 16 stamps on each side
// - one request is worked at a time; the next beat is taken once the
//   sequencer is back to idle
// - the result sits in an output register, so the next request is accepted
//   while a beat still waits for m_tready; a new result then waits for it
// - reset clears line_count and the output valid; table contents are kept
//   undefined until written
`default_nettype none
module timestamp_range_line_search_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // stream in
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // line_index, has_time, time_value, end_time, from_line
  input  wire logic [tsls_pkg::IN_DATA_W-1:0]  s_tdata,
  // req_type
  input  wire logic [tsls_pkg::REQ_W-1:0]      s_tuser,
  // stream out
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // position, outcome, start_line, end_line, out_of_order
  output logic [tsls_pkg::OUT_DATA_W-1:0]      m_tdata,
  // configuration
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [2:0]                      paddr,
  input  wire logic [31:0]                     pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import tsls_pkg::*;

  dp_op_t               op;
  dp_status_t           status;
  logic [CNT_W-1:0]     line_count;
  logic                 cfg_wr;

  // register write completes in the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count <= '0;
    end else if (cfg_wr) begin
      line_count <= pwdata[CNT_W-1:0];
    end
  end

  // only line_count decodes; other words read as zero
  assign prdata = paddr[2] ? 32'd0 : {{(32 - CNT_W){1'b0}}, line_count};

  tsls_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .status   (status),
    .s_tready (s_tready),
    .op       (op)
  );

  tsls_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .line_count (line_count),
    .m_tready   (m_tready),
    .m_tvalid   (m_tvalid),
    .m_tdata    (m_tdata),
    .status     (status)
  );

endmodule
`default_nettype wire

### hdl/tsls_datapath.sv
// search datapath: line table, search and scan registers, result register
`default_nettype none
module tsls_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire tsls_pkg::dp_op_t              op,
  input  wire logic [tsls_pkg::IN_DATA_W-1:0] s_tdata,
  input  wire logic [tsls_pkg::REQ_W-1:0]    s_tuser,
  input  wire logic [tsls_pkg::CNT_W-1:0]    line_count,
  input  wire logic                          m_tready,
  output logic                               m_tvalid,
  output logic [tsls_pkg::OUT_DATA_W-1:0]    m_tdata,
  output tsls_pkg::dp_status_t               status
);
  import tsls_pkg::*;

  entry_t mem [LINE_DEPTH];
  entry_t rd_data;

  logic [ADDR_W-1:0] in_index;
  logic              in_has;
  logic [TIME_W-1:0] in_tv;
  logic [TIME_W-1:0] in_te;
  logic [ADDR_W-1:0] in_from;

  logic [CNT_W-1:0]  cnt;
  logic              is_range;
  logic              stage;
  logic [TIME_W-1:0] te;
  logic [TIME_W-1:0] time_q;
  logic [ADDR_W-1:0] cur_from;
  logic [CNT_W-1:0]  low;
  logic [CNT_W-1:0]  high;
  logic [CNT_W-1:0]  mid;
  logic [CNT_W-1:0]  k;
  logic [CNT_W-1:0]  stop;
  logic              found;
  logic [ADDR_W-1:0] at;
  logic [TIME_W-1:0] ts;
  logic              final_pass;
  logic [POS_W-1:0]  fpos;
  logic [ADDR_W-1:0] fline;
  logic              fooo;
  logic [CNT_W-1:0]  lowest;
  logic [CNT_W-1:0]  probe;
  logic [WIN_W-1:0]  nb;
  logic              have;
  logic [TIME_W-1:0] prev;
  logic [TIME_W-1:0] closest;
  logic [POS_W-1:0]  s_pos;
  logic [ADDR_W-1:0] s_line;
  logic              s_ooo;
  logic [POS_W-1:0]  res_pos;
  logic [OUTC_W-1:0] res_outc;
  logic [ADDR_W-1:0] res_sline;
  logic [CNT_W-1:0]  res_eline;
  logic              res_ooo;
  logic              out_valid;
  logic [OUT_DATA_W-1:0] out_data;

  logic [ADDR_W-1:0] rd_addr;
  logic [CNT_W-1:0]  probe_dec;
  logic [CNT_W-1:0]  cnt_last;
  logic [CNT_W-1:0]  from_ext;
  logic [CNT_W-1:0]  mid_n;
  logic [SUM_W-1:0]  mid_gap;
  logic [SUM_W-1:0]  low_gap;
  logic [SUM_W-1:0]  line_fw;
  logic [CNT_W-1:0]  line_ext;
  logic [CNT_W-1:0]  end_n;
  logic              bk_viol;
  logic              fw_viol;
  logic              need_second;
  logic              mem_we;

  assign in_index = s_tdata[IN_INDEX_LSB +: ADDR_W];
  assign in_has   = s_tdata[IN_HAS_BIT];
  assign in_tv    = s_tdata[IN_TV_LSB +: TIME_W];
  assign in_te    = s_tdata[IN_TE_LSB +: TIME_W];
  assign in_from  = s_tdata[IN_FROM_LSB +: ADDR_W];

  // count above the table depth acts as the depth
  assign cnt       = (line_count > CNT_W'(LINE_DEPTH)) ? CNT_W'(LINE_DEPTH) : line_count;
  assign cnt_last  = cnt - CNT_W'(1);
  assign from_ext  = {1'b0, cur_from};
  assign mid_n     = low + ((high - low) >> 1);
  assign mid_gap   = {1'b0, mid_n} + SUM_W'(GAP_LIMIT);
  assign low_gap   = {1'b0, low} + SUM_W'(GAP_LIMIT);
  assign line_ext  = {1'b0, fline};
  assign line_fw   = {1'b0, line_ext} + SUM_W'(ORDER_SCAN);
  assign probe_dec = probe - CNT_W'(1);
  assign end_n     = (fpos == POS_AFTER) ? cnt : line_ext;

  assign bk_viol = rd_data.has && have && (rd_data.stamp > prev);
  assign fw_viol = rd_data.has && have && (prev > rd_data.stamp);
  assign need_second = is_range && !stage && ((fpos == POS_BEFORE) || (fpos == POS_AT));
  assign mem_we  = (op == OP_LOAD) && (s_tuser == REQ_WRITE);

  always_comb begin
    unique case (op)
      OP_BK_RD: rd_addr = probe_dec[ADDR_W-1:0];
      OP_FW_RD: rd_addr = probe[ADDR_W-1:0];
      default:  rd_addr = k[ADDR_W-1:0];
    endcase
  end

  // single port line table, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[in_index] <= '{has: in_has, stamp: in_tv};
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    unique case (op)
      OP_LOAD: begin
        is_range <= (s_tuser == REQ_RANGE);
        stage    <= 1'b0;
        te       <= in_te;
        time_q   <= in_tv;
        cur_from <= (s_tuser == REQ_RANGE) ? '0 : in_from;
        res_pos   <= POS_EMPTY;
        res_outc  <= OUTC_END_LE;
        res_sline <= '0;
        res_eline <= '0;
        res_ooo   <= 1'b0;
      end
      OP_EMPTY: begin
        fpos  <= POS_EMPTY;
        fline <= '0;
        fooo  <= 1'b0;
      end
      OP_FSTART: begin
        low        <= (from_ext < cnt_last) ? from_ext : cnt_last;
        high       <= cnt;
        final_pass <= 1'b0;
      end
      OP_BS_STEP: begin
        mid   <= mid_n;
        k     <= mid_n;
        stop  <= (mid_gap > {1'b0, high}) ? high : mid_gap[CNT_W-1:0];
        found <= 1'b0;
      end
      OP_FINAL_SCAN: begin
        k          <= low;
        stop       <= (low_gap > {1'b0, cnt}) ? cnt : low_gap[CNT_W-1:0];
        found      <= 1'b0;
        final_pass <= 1'b1;
      end
      OP_SCAN_EV: begin
        if (rd_data.has) begin
          found <= 1'b1;
          at    <= k[ADDR_W-1:0];
          ts    <= rd_data.stamp;
        end else begin
          k <= k + CNT_W'(1);
        end
      end
      OP_SCAN_DONE: begin
        if (!final_pass) begin
          if (found && (ts < time_q)) begin
            low <= {1'b0, at} + CNT_W'(1);
          end else begin
            high <= mid;
          end
        end else if (!found) begin
          fpos  <= (low == '0) ? POS_NONE : POS_AFTER;
          fline <= (low == '0) ? '0 : cnt_last[ADDR_W-1:0];
        end else if ((low == '0) && (ts > time_q)) begin
          fpos  <= POS_BEFORE;
          fline <= '0;
        end else begin
          fpos  <= POS_AT;
          fline <= at;
        end
      end
      OP_ORD_START: begin
        lowest <= (line_ext > CNT_W'(ORDER_SCAN)) ? line_ext - CNT_W'(ORDER_SCAN) : '0;
        probe  <= line_ext;
        nb     <= '0;
        have   <= 1'b0;
        fooo   <= 1'b0;
      end
      OP_BK_RD: begin
        probe <= probe_dec;
      end
      OP_BK_EV: begin
        if (bk_viol) begin
          fooo <= 1'b1;
        end else if (rd_data.has) begin
          prev <= rd_data.stamp;
          have <= 1'b1;
          nb   <= nb + WIN_W'(1);
          if (nb == '0) begin
            closest <= rd_data.stamp;
          end
        end
      end
      OP_FW_START: begin
        probe <= line_ext;
        stop  <= (line_fw > {1'b0, cnt}) ? cnt : line_fw[CNT_W-1:0];
        nb    <= '0;
        prev  <= closest;
      end
      OP_FW_EV: begin
        probe <= probe + CNT_W'(1);
        if (fw_viol) begin
          fooo <= 1'b1;
        end else if (rd_data.has) begin
          prev <= rd_data.stamp;
          have <= 1'b1;
          nb   <= nb + WIN_W'(1);
        end
      end
      OP_FIND_DONE: begin
        res_pos   <= POS_EMPTY;
        res_sline <= '0;
        res_eline <= '0;
        res_ooo   <= 1'b0;
        if (!is_range) begin
          res_pos   <= fpos;
          res_outc  <= OUTC_LIMITS;
          res_sline <= fline;
          res_ooo   <= fooo;
        end else if (!stage) begin
          if (need_second) begin
            s_pos    <= fpos;
            s_line   <= fline;
            s_ooo    <= fooo;
            stage    <= 1'b1;
            time_q   <= te;
            cur_from <= fline;
          end else if (fpos == POS_AFTER) begin
            res_outc <= OUTC_AFTER;
          end else begin
            res_outc <= OUTC_NO_STAMP;
          end
        end else if (fpos == POS_EMPTY) begin
          res_outc <= OUTC_NO_STAMP;
        end else if (fpos == POS_BEFORE) begin
          res_outc <= OUTC_BEFORE;
        end else if (end_n <= {1'b0, s_line}) begin
          res_outc <= (s_pos == POS_BEFORE) ? OUTC_BEFORE : OUTC_NO_LINES;
        end else begin
          res_outc  <= OUTC_LIMITS;
          res_sline <= s_line;
          res_eline <= end_n;
          res_ooo   <= s_ooo | fooo;
        end
      end
      OP_OUT: begin
        out_data <= {res_ooo, res_eline, res_sline, res_outc, res_pos};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op == OP_OUT) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  always_comb begin
    status.in_req      = s_tuser;
    status.range_bad   = (in_te <= in_tv);
    status.cnt_zero    = (cnt == '0);
    status.low_lt_high = (low < high);
    status.scan_more   = (k < stop);
    status.rd_hit      = rd_data.has;
    status.final_pass  = final_pass;
    status.bk_more     = (probe > lowest) && (nb < WIN_W'(ORDER_WINDOW));
    status.fw_more     = (probe < stop) && (nb < WIN_W'(ORDER_WINDOW));
    status.bk_viol     = bk_viol;
    status.fw_viol     = fw_viol;
    status.need_second = need_second;
    status.out_busy    = out_valid && !m_tready;
  end

  // table reads of a scan stay inside the lines in use
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (op == OP_SCAN_RD) |-> (k < cnt))
    else $error("scan read beyond line count");

  // a search that starts on a non-empty table has a non-empty interval
  a_start_interval: assert property (@(posedge clk) disable iff (rst)
    (op == OP_FSTART) |=> (low < high))
    else $error("search interval empty at start");

  // a probe hit lies inside the probed half of the interval
  a_probe_hit: assert property (@(posedge clk) disable iff (rst)
    ((op == OP_SCAN_DONE) && !final_pass && found) |->
      (({1'b0, at} >= mid) && ({1'b0, at} < high)))
    else $error("probe hit outside interval");

endmodule
`default_nettype wire

### hdl/tsls_ctrl.sv
// search sequencer: steps the datapath through probes, scans and results
`default_nettype none
module tsls_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  input  wire tsls_pkg::dp_status_t status,
  output logic                      s_tready,
  output tsls_pkg::dp_op_t          op
);
  import tsls_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_FSTART = 4'd1;
  localparam logic [3:0] S_BS     = 4'd2;
  localparam logic [3:0] S_SRD    = 4'd3;
  localparam logic [3:0] S_SEV    = 4'd4;
  localparam logic [3:0] S_SDONE  = 4'd5;
  localparam logic [3:0] S_OSTART = 4'd6;
  localparam logic [3:0] S_BRD    = 4'd7;
  localparam logic [3:0] S_BEV    = 4'd8;
  localparam logic [3:0] S_FRD    = 4'd9;
  localparam logic [3:0] S_FEV    = 4'd10;
  localparam logic [3:0] S_FDONE  = 4'd11;
  localparam logic [3:0] S_RES    = 4'd12;

  logic [3:0] state;
  logic [3:0] state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          op = OP_LOAD;
          if (status.in_req == REQ_FIND) begin
            state_next = S_FSTART;
          end else if (status.in_req == REQ_RANGE) begin
            state_next = status.range_bad ? S_RES : S_FSTART;
          end
        end
      end
      S_FSTART: begin
        if (status.cnt_zero) begin
          op         = OP_EMPTY;
          state_next = S_FDONE;
        end else begin
          op         = OP_FSTART;
          state_next = S_BS;
        end
      end
      S_BS: begin
        op         = status.low_lt_high ? OP_BS_STEP : OP_FINAL_SCAN;
        state_next = S_SRD;
      end
      S_SRD: begin
        if (status.scan_more) begin
          op         = OP_SCAN_RD;
          state_next = S_SEV;
        end else begin
          state_next = S_SDONE;
        end
      end
      S_SEV: begin
        op         = OP_SCAN_EV;
        state_next = status.rd_hit ? S_SDONE : S_SRD;
      end
      S_SDONE: begin
        op         = OP_SCAN_DONE;
        state_next = status.final_pass ? S_OSTART : S_BS;
      end
      S_OSTART: begin
        op         = OP_ORD_START;
        state_next = S_BRD;
      end
      S_BRD: begin
        if (status.bk_more) begin
          op         = OP_BK_RD;
          state_next = S_BEV;
        end else begin
          op         = OP_FW_START;
          state_next = S_FRD;
        end
      end
      S_BEV: begin
        op         = OP_BK_EV;
        state_next = status.bk_viol ? S_FDONE : S_BRD;
      end
      S_FRD: begin
        if (status.fw_more) begin
          op         = OP_FW_RD;
          state_next = S_FEV;
        end else begin
          state_next = S_FDONE;
        end
      end
      S_FEV: begin
        op         = OP_FW_EV;
        state_next = status.fw_viol ? S_FDONE : S_FRD;
      end
      S_FDONE: begin
        op         = OP_FIND_DONE;
        state_next = status.need_second ? S_FSTART : S_RES;
      end
      S_RES: begin
        if (!status.out_busy) begin
          op         = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

### tb/tb_top.sv
// testbench top level for the timestamp range line search unit
`default_nettype none
module tb_top;
  import tsls_pkg::*;

  localparam int STALL_LIMIT = 400000;
  localparam logic [TIME_W-1:0] T_MAX = {TIME_W{1'b1}};
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    logic [REQ_W-1:0]  kind;
    logic [ADDR_W-1:0] idx;
    logic              has;
    logic [TIME_W-1:0] tv;
    logic [TIME_W-1:0] te;
    logic [ADDR_W-1:0] from;
  } req_t;

  typedef struct {
    logic [POS_W-1:0]  pos;
    logic [OUTC_W-1:0] outc;
    logic [ADDR_W-1:0] sline;
    logic [CNT_W-1:0]  eline;
    logic              ooo;
  } res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // from_line, end_time, time_value, has_time, line_index in the low bits
  logic [IN_DATA_W-1:0] s_tdata = '0;
  // req_type
  logic [REQ_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b1;
  // out_of_order, end_line, start_line, outcome, position from the top down
  logic [OUT_DATA_W-1:0] m_tdata;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  timestamp_range_line_search_unit u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  req_t pending_q[$];
  res_t answer_q[$];
  int   errors = 0;
  bit   idle_on = 1'b1;

  // predictor state: table copy and line count as the block sees them
  logic [TIME_W-1:0] stamp_m[LINE_DEPTH];
  logic              valid_m[LINE_DEPTH];
  logic [CNT_W-1:0]  count_m = '0;

  // stimulus side view of the table, so that only written lines are ever read
  logic [TIME_W-1:0] stamp_g[LINE_DEPTH];
  bit                written_g[LINE_DEPTH];
  int                count_g = 0;
  int                gap_lo = -1, gap_hi = -1;

  function automatic int lines_in_use();
    return (count_m > LINE_DEPTH) ? LINE_DEPTH : int'(count_m);
  endfunction

  // first stamped line in [start, stop), never looking further than the gap limit
  function automatic bit next_stamp(input int start, input int stop, output int at,
                                    output logic [TIME_W-1:0] ts);
    int lim;
    lim = start + GAP_LIMIT;
    if (lim > stop) lim = stop;
    at = 0;
    ts = '0;
    for (int k = start; k < lim; k++) begin
      if (valid_m[k]) begin
        at = k;
        ts = stamp_m[k];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // up to a window of stamps before the line and after it must rise monotonically
  function automatic bit order_bad(input int line, input int cnt);
    logic [TIME_W-1:0] near[ORDER_WINDOW];
    logic [TIME_W-1:0] prev;
    int n, lowest, probe, stop, taken;
    bit have;
    n = 0;
    taken = 0;
    have = 1'b0;
    prev = '0;
    lowest = (line > ORDER_SCAN) ? line - ORDER_SCAN : 0;
    probe = line;
    while (probe > lowest && n < ORDER_WINDOW) begin
      probe--;
      if (valid_m[probe]) begin
        near[n] = stamp_m[probe];
        n++;
      end
    end
    for (int i = n; i > 0; i--) begin
      if (have && prev > near[i-1]) return 1'b1;
      prev = near[i-1];
      have = 1'b1;
    end
    stop = line + ORDER_SCAN;
    if (stop > cnt) stop = cnt;
    for (probe = line; probe < stop && taken < ORDER_WINDOW; probe++) begin
      if (valid_m[probe]) begin
        if (have && prev > stamp_m[probe]) return 1'b1;
        prev = stamp_m[probe];
        have = 1'b1;
        taken++;
      end
    end
    return 1'b0;
  endfunction

  // lower bound search for the first line stamped at or after t
  function automatic void locate_line(input logic [TIME_W-1:0] t, input int from,
                                      output bit ok, output logic [POS_W-1:0] pos,
                                      output int line, output bit ooo);
    int cnt, lo, hi, mid, at;
    logic [TIME_W-1:0] ts;
    bit hit;
    cnt = lines_in_use();
    ok = 1'b0;
    pos = POS_EMPTY;
    line = 0;
    ooo = 1'b0;
    if (cnt == 0) return;
    ok = 1'b1;
    lo = (from < cnt - 1) ? from : cnt - 1;
    hi = cnt;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      hit = next_stamp(mid, hi, at, ts);
      if (hit && ts < t) lo = at + 1;
      else hi = mid;
    end
    hit = next_stamp(lo, cnt, at, ts);
    if (!hit) begin
      pos = (lo == 0) ? POS_NONE : POS_AFTER;
      line = (lo == 0) ? 0 : cnt - 1;
    end else if (lo == 0 && ts > t) begin
      pos = POS_BEFORE;
    end else begin
      pos = POS_AT;
      line = at;
    end
    ooo = order_bad(line, cnt);
  endfunction

  // apply one accepted request beat to the predictor, queue its answer if any
  function automatic void predict_request(input req_t r);
    res_t a;
    bit sok, eok, sooo, eooo;
    logic [POS_W-1:0] spos, epos;
    int sl, el;
    a = '{default: '0};
    case (r.kind)
      REQ_WRITE: begin
        stamp_m[r.idx] = r.tv;
        valid_m[r.idx] = r.has;
        return;
      end
      REQ_FIND: begin
        locate_line(r.tv, int'(r.from), sok, spos, sl, sooo);
        a.pos = spos;
        a.sline = sl[ADDR_W-1:0];
        a.ooo = sooo;
      end
      REQ_RANGE: begin
        if (r.te <= r.tv) begin
          a.outc = OUTC_END_LE;
        end else begin
          locate_line(r.tv, 0, sok, spos, sl, sooo);
          if (!sok || spos == POS_NONE) a.outc = OUTC_NO_STAMP;
          else if (spos == POS_AFTER) a.outc = OUTC_AFTER;
          else begin
            locate_line(r.te, sl, eok, epos, el, eooo);
            if (!eok) a.outc = OUTC_NO_STAMP;
            else if (epos == POS_BEFORE) a.outc = OUTC_BEFORE;
            else begin
              if (epos == POS_AFTER) el = lines_in_use();
              if (el <= sl) begin
                a.outc = (spos == POS_BEFORE) ? OUTC_BEFORE : OUTC_NO_LINES;
              end else begin
                a.outc = OUTC_LIMITS;
                a.sline = sl[ADDR_W-1:0];
                a.eline = el[CNT_W-1:0];
                a.ooo = sooo | eooo;
              end
            end
          end
        end
      end
      default: return;
    endcase
    answer_q = {answer_q, a};
  endfunction

  // driver: request beats from the pending queue, with random gaps
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        req_t r;
        r = pending_q.pop_front();
        s_tdata <= {7'd0, r.from, r.te, r.tv, r.has, r.idx};
        s_tuser <= r.kind;
        s_tvalid <= 1'b1;
        if (idle_on && $urandom_range(0, 9) == 0) gap_left <= $urandom_range(1, 19);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result side back pressure in bursts
  int hold_left = 0;
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= (hold_left == 1);
    end else if (idle_on && !rst && $urandom_range(0, 11) == 0) begin
      hold_left <= $urandom_range(1, 19);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // monitor: compare each result beat, then predict each accepted request beat
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (answer_q.size() == 0) begin
          $error("result beat with no request waiting: %h", m_tdata);
          errors++;
        end else begin
          res_t a;
          a = answer_q.pop_front();
          if (m_tdata[2:0] != a.pos) begin
            $error("position exp %0d got %0d", a.pos, m_tdata[2:0]);
            errors++;
          end
          if (m_tdata[5:3] != a.outc) begin
            $error("outcome exp %0d got %0d", a.outc, m_tdata[5:3]);
            errors++;
          end
          if (m_tdata[17:6] != a.sline) begin
            $error("start_line exp %0d got %0d", a.sline, m_tdata[17:6]);
            errors++;
          end
          if (m_tdata[30:18] != a.eline) begin
            $error("end_line exp %0d got %0d", a.eline, m_tdata[30:18]);
            errors++;
          end
          if (m_tdata[31] != a.ooo) begin
            $error("out_of_order exp %0d got %0d", a.ooo, m_tdata[31]);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        req_t r;
        r.idx  = s_tdata[11:0];
        r.has  = s_tdata[12];
        r.tv   = s_tdata[60:13];
        r.te   = s_tdata[108:61];
        r.from = s_tdata[120:109];
        r.kind = s_tuser;
        predict_request(r);
      end
    end
  end

  // watchdog on cycles without any beat or register write
  int quiet = 0;
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [TIME_W-1:0] rand_time();
    return TIME_W'({$urandom, $urandom});
  endfunction

  task automatic put_write(input int idx, input logic has, input logic [TIME_W-1:0] tv);
    req_t r;
    r = '{kind: REQ_WRITE, idx: idx[ADDR_W-1:0], has: has, tv: tv,
          te: rand_time(), from: ADDR_W'($urandom)};
    stamp_g[idx] = tv;
    written_g[idx] = 1'b1;
    pending_q = {pending_q, r};
  endtask

  task automatic put_req(input logic [REQ_W-1:0] kind, input logic [TIME_W-1:0] tv,
                         input logic [TIME_W-1:0] te, input int from);
    req_t r;
    r = '{kind: kind, idx: ADDR_W'($urandom), has: 1'($urandom), tv: tv, te: te,
          from: from[ADDR_W-1:0]};
    pending_q = {pending_q, r};
  endtask

  // mostly rising stamps, some lines without a stamp, none inside the gap band
  task automatic fill_lines(input int lo, input int hi);
    for (int i = lo; i < hi; i++)
      put_write(i, !(i >= gap_lo && i < gap_hi) && $urandom_range(0, 99) < 85,
                48'(i) * 1000 + $urandom_range(0, 999));
  endtask

  function automatic int written_prefix();
    for (int i = 0; i < LINE_DEPTH; i++)
      if (!written_g[i]) return i;
    return LINE_DEPTH;
  endfunction

  // search time near a stamp in use, or at the extremes, or anywhere
  function automatic logic [TIME_W-1:0] pick_time();
    int r, used;
    used = (count_g > LINE_DEPTH) ? LINE_DEPTH : count_g;
    r = $urandom_range(0, 99);
    if (r < 55 && used > 0) return stamp_g[$urandom_range(0, used - 1)]
                                    + $urandom_range(0, 2) - 1;
    if (r < 65) return '0;
    if (r < 75) return T_MAX;
    return rand_time();
  endfunction

  task automatic run_mix(input int n);
    int r, pre;
    logic [TIME_W-1:0] tv, te;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      pre = written_prefix();
      if (r < 18) begin
        int idx;
        idx = ($urandom_range(0, 3) != 0 && pre > 0) ? $urandom_range(0, pre - 1)
                                                     : $urandom_range(0, LINE_DEPTH - 1);
        put_write(idx, $urandom_range(0, 99) < 85,
                  ($urandom_range(0, 9) == 0) ? rand_time()
                                              : 48'(idx) * 1000 + $urandom_range(0, 999));
      end else if (r < 22) begin
        put_req(REQ_UNUSED, rand_time(), rand_time(), $urandom);
      end else if (r < 60) begin
        put_req(REQ_FIND, pick_time(), rand_time(),
                ($urandom_range(0, 1) != 0) ? $urandom_range(0, LINE_DEPTH - 1)
                                            : $urandom_range(0, count_g));
      end else begin
        tv = pick_time();
        case ($urandom_range(0, 4))
          0: te = tv + $urandom_range(1, 5000);
          1: te = pick_time();
          2: te = T_MAX;
          3: te = tv - $urandom_range(0, 3);
          default: te = rand_time();
        endcase
        put_req(REQ_RANGE, tv, te, $urandom);
      end
    end
  endtask

  // wait until every request beat is taken and every answer came back
  task automatic drain();
    while (pending_q.size() > 0 || s_tvalid) @(posedge clk);
    while (answer_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_line_count(input int v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= '0;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    count_m = v[CNT_W-1:0];
    count_g = v;
  endtask

  initial begin
    int pre, cnt;
    for (int i = 0; i < LINE_DEPTH; i++) begin
      written_g[i] = 1'b0;
      valid_m[i] = 1'b0;
      stamp_m[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // empty table, unused request kind, writes far above the count
    put_req(REQ_FIND, '0, '0, 0);
    put_req(REQ_FIND, T_MAX, T_MAX, LINE_DEPTH - 1);
    put_req(REQ_RANGE, 48'd5, 48'd1, 0);
    put_req(REQ_RANGE, '0, T_MAX, 0);
    put_req(REQ_UNUSED, T_MAX, T_MAX, LINE_DEPTH - 1);
    put_write(LINE_DEPTH - 1, 1'b1, T_MAX);
    put_write(2048, 1'b0, '0);
    for (int i = 0; i < 8; i++) put_write(i, 1'b0, rand_time());
    drain();

    // lines without any stamp
    set_line_count(8);
    put_req(REQ_FIND, rand_time(), '0, 3);
    put_req(REQ_RANGE, '0, T_MAX, 0);
    drain();

    // a short sorted table whose last line carries no stamp
    fill_lines(0, 64);
    put_write(62, 1'b1, 48'd62500);
    put_write(63, 1'b0, '0);
    drain();
    set_line_count(64);
    put_req(REQ_FIND, '0, '0, 0);
    put_req(REQ_FIND, T_MAX, '0, 0);
    put_req(REQ_FIND, 48'd20500, '0, LINE_DEPTH - 1);
    put_req(REQ_FIND, 48'd20500, '0, 10);
    put_req(REQ_RANGE, '0, T_MAX, 0);
    put_req(REQ_RANGE, T_MAX - 1, T_MAX, 0);
    put_req(REQ_RANGE, '0, 48'd1, 0);
    put_req(REQ_RANGE, 48'd20500, 48'd20501, 0);
    drain();

    // phases over several line counts, the table growing as it goes
    for (int p = 0; p < 8; p++) begin
      pre = written_prefix();
      fill_lines(pre, pre + $urandom_range(15, 40));
      drain();
      pre = written_prefix();
      case (p)
        0: cnt = 1;
        1: cnt = 2;
        7: cnt = pre;
        default: cnt = $urandom_range(1, pre);
      endcase
      set_line_count(cnt);
      run_mix(55);
      drain();
    end

    // a stampless band wider than the gap scan, no idling
    gap_lo = written_prefix() + 10;
    gap_hi = gap_lo + 300;
    fill_lines(written_prefix(), gap_hi + 30);
    drain();
    idle_on = 1'b0;
    set_line_count(written_prefix());
    run_mix(80);
    drain();

    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire

### sim.f
hdl/tsls_pkg.sv
hdl/tsls_datapath.sv
hdl/tsls_ctrl.sv
hdl/timestamp_range_line_search_unit.sv
tb/tb_top.sv
